// ===== rtl/icsr_pkg.sv =====
// ----------------------------------------------------------------------------
// icsr_pkg: shared types and constants for the indexed color scaler
// Field widths, register codes, queue item and back-end state encoding.
// ----------------------------------------------------------------------------
package icsr_pkg;

  // defaults for the top-level parameters
  localparam int FB_ROW_LENGTH_DEF   = 240;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_REPEAT_DEF      = 4;

  // field widths
  localparam int POS_W     = 10;  // source column / row, region origin
  localparam int SIZE_W    = 11;  // source size, region span
  localparam int DEST_W    = 9;   // destination width (height is zero-extended)
  localparam int DESTH_W   = 8;   // destination height
  localparam int IDX_W     = 8;   // palette index
  localparam int CH_W      = 8;   // one color channel
  localparam int COLOR_W   = 16;  // RGB565
  localparam int FB_W      = 17;  // framebuffer index
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = SIZE_W;

  // axis divider: remainder holds k*dest + span - 1 and span << DEST_W
  localparam int REM_W     = SIZE_W + DEST_W;
  localparam int GAP_W     = SIZE_W + 5;
  localparam int DIV_STEPS = DEST_W + 1;  // one extra step flags quotient overflow
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  // front/back queue, depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_REGION_LEFT   = 3'd2,
    REG_REGION_TOP    = 3'd3,
    REG_REGION_WIDTH  = 3'd4,
    REG_REGION_HEIGHT = 3'd5,
    REG_DEST_WIDTH    = 3'd6,
    REG_DEST_HEIGHT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  source_width;
    logic [SIZE_W-1:0]  source_height;
    logic [POS_W-1:0]   region_left;
    logic [POS_W-1:0]   region_top;
    logic [SIZE_W-1:0]  region_width;
    logic [SIZE_W-1:0]  region_height;
    logic [DEST_W-1:0]  dest_width;
    logic [DESTH_W-1:0] dest_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    source_width:  11'd640,
    source_height: 11'd480,
    region_left:   10'd0,
    region_top:    10'd0,
    region_width:  11'd640,
    region_height: 11'd480,
    dest_width:    9'd400,
    dest_height:   8'd240
  };

  // classified pixel handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } pix_t;

  // per-phase strobes from the back-end sequencer to both axis units
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic init;
    logic cnt;
  } axis_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_INIT,
    B_CNT,
    B_PREP,
    B_EMIT
  } back_state_t;

  function automatic logic [COLOR_W-1:0] pack565(input logic [CH_W-1:0] r,
                                                 input logic [CH_W-1:0] g,
                                                 input logic [CH_W-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== rtl/icsr_in_if.sv =====
// ----------------------------------------------------------------------------
// icsr_in_if: request channel into the scaler
// Valid/ready handshake with palette-write or source-pixel payload.
// ----------------------------------------------------------------------------
interface icsr_in_if;
  import icsr_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [POS_W-1:0]   source_x;
  logic [POS_W-1:0]   source_y;
  logic [IDX_W-1:0]   color_index;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;

  modport source (output valid, op, source_x, source_y, color_index, red, green, blue,
                  input ready);
  modport sink   (input valid, op, source_x, source_y, color_index, red, green, blue,
                  output ready);
endinterface

// ===== rtl/icsr_out_if.sv =====
// ----------------------------------------------------------------------------
// icsr_out_if: result channel out of the scaler
// Valid/ready handshake carrying framebuffer index, color and run end.
// ----------------------------------------------------------------------------
interface icsr_out_if;
  import icsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [FB_W-1:0]    fb_index;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_of_run;

  modport source (output valid, fb_index, pixel_color, last_of_run, input ready);
  modport sink   (input valid, fb_index, pixel_color, last_of_run, output ready);
endinterface

// ===== rtl/icsr_front.sv =====
// ----------------------------------------------------------------------------
// icsr_front: request intake and palette
// Palette writes update the RGB565 store; pixels read their color and are
// staged for the queue.
// ----------------------------------------------------------------------------
module icsr_front #(
  parameter int PALETTE_ENTRIES = icsr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  icsr_in_if.sink         in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output icsr_pkg::pix_t  push_data
);
  import icsr_pkg::*;

  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];

  logic               accept;
  logic               is_pixel;
  logic               idx_ok;
  logic [PAL_AW-1:0]  addr;

  logic               st_valid_r, st_valid_nxt;
  logic [POS_W-1:0]   x_r, y_r;
  logic               ok_r;
  logic [COLOR_W-1:0] rd_r;

  assign in_ch.ready = !st_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pixel    = (in_ch.op == OP_PIXEL);
  assign idx_ok      = int'(in_ch.color_index) < PALETTE_ENTRIES;
  assign addr        = in_ch.color_index[PAL_AW-1:0];

  // out-of-range index: write dropped, pixel drawn black
  always_ff @(posedge clk) begin
    if (accept && !is_pixel && idx_ok) begin
      palette_mem[addr] <= pack565(in_ch.red, in_ch.green, in_ch.blue);
    end
    if (accept && is_pixel && idx_ok) begin
      rd_r <= palette_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      x_r  <= in_ch.source_x;
      y_r  <= in_ch.source_y;
      ok_r <= idx_ok;
    end
  end

  assign st_valid_nxt = (accept && is_pixel) || (st_valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  assign push_valid       = st_valid_r;
  assign push_data.x      = x_r;
  assign push_data.y      = y_r;
  assign push_data.color  = ok_r ? rd_r : '0;

endmodule

// ===== rtl/icsr_queue.sv =====
// ----------------------------------------------------------------------------
// icsr_queue: short pixel queue between front and back
// Register FIFO of QUEUE_DEPTH entries.
// ----------------------------------------------------------------------------
module icsr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  icsr_pkg::pix_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output icsr_pkg::pix_t  pop_data
);
  import icsr_pkg::*;

  pix_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/icsr_axis.sv =====
// ----------------------------------------------------------------------------
// icsr_axis: destination-run finder for one axis
// Finds the first destination position mapping onto a source position with
// a restoring divider, then counts the run length one step per cycle.
// ----------------------------------------------------------------------------
module icsr_axis #(
  parameter  int MAX_REPEAT = icsr_pkg::MAX_REPEAT_DEF,
  localparam int CNT_W      = $clog2(MAX_REPEAT + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icsr_pkg::axis_ctl_t           ctl,
  input  logic [icsr_pkg::POS_W-1:0]    pos,
  input  logic [icsr_pkg::POS_W-1:0]    start,
  input  logic [icsr_pkg::SIZE_W-1:0]   span,
  input  logic [icsr_pkg::SIZE_W-1:0]   limit,
  input  logic [icsr_pkg::DEST_W-1:0]   dest,
  output logic [icsr_pkg::DEST_W-1:0]   d_lo,
  output logic [CNT_W-1:0]              hits,
  output logic                          done
);
  import icsr_pkg::*;

  // lowest hit is ceil(k*dest/span) = floor((k*dest + span - 1) / span)
  logic               none_r, none_nxt;
  logic               zero_r, zero_nxt;     // run starts at 0, no upper bound
  logic               clamp_r, clamp_nxt;   // position is the clamp column/row
  logic [POS_W-1:0]   k_r, k_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   dv_r, dv_nxt;
  logic [DEST_W:0]    q_r, q_nxt;
  logic [DEST_W:0]    cand_r, cand_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;       // (k+1)*dest - cand*span, two's complement
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [SIZE_W-1:0]  pos_ext;
  logic               beyond, at_clamp, below, span_zero, ge, gap_pos, more;

  assign pos_ext   = {1'b0, pos};
  assign beyond    = pos_ext >= limit;
  assign at_clamp  = (pos_ext + 1'b1) == limit;
  assign below     = pos < start;
  assign span_zero = (span == '0);
  assign ge        = rem_r >= dv_r;
  assign gap_pos   = !gap_r[GAP_W-1] && (gap_r != '0);
  assign more      = (cand_r < {1'b0, dest}) && (clamp_r || zero_r || gap_pos);

  assign done = none_r || (cnt_r == CNT_W'(MAX_REPEAT)) || !more;
  assign d_lo = zero_r ? '0 : q_r[DEST_W-1:0];
  assign hits = cnt_r;

  always_comb begin
    none_nxt  = none_r;
    zero_nxt  = zero_r;
    clamp_nxt = clamp_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    cand_nxt  = cand_r;
    gap_nxt   = gap_r;
    cnt_nxt   = cnt_r;
    if (ctl.load) begin
      k_nxt     = pos - start;
      clamp_nxt = at_clamp;
      zero_nxt  = below || span_zero;
      none_nxt  = beyond || (below && !at_clamp) ||
                  (!below && span_zero && (pos != start));
      cnt_nxt   = '0;
    end
    if (ctl.mul) begin
      rem_nxt = REM_W'(k_r) * REM_W'(dest) + REM_W'(span) - 1'b1;
      dv_nxt  = {span, {DEST_W{1'b0}}};
      q_nxt   = '0;
    end
    if (ctl.div) begin
      rem_nxt = ge ? rem_r - dv_r : rem_r;
      q_nxt   = {q_r[DEST_W-1:0], ge};
      dv_nxt  = dv_r >> 1;
    end
    if (ctl.init) begin
      // top quotient bit set: first hit lies past any destination
      none_nxt = none_r || (!zero_r && q_r[DEST_W]);
      cand_nxt = zero_r ? '0 : {1'b0, q_r[DEST_W-1:0]};
      gap_nxt  = GAP_W'(dest) - GAP_W'(span) + GAP_W'(1) + GAP_W'(rem_r[SIZE_W-1:0]);
      cnt_nxt  = '0;
    end
    if (ctl.cnt && !done) begin
      cnt_nxt  = cnt_r + 1'b1;
      cand_nxt = cand_r + 1'b1;
      gap_nxt  = gap_r - GAP_W'(span);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      none_r  <= 1'b1;
      zero_r  <= 1'b0;
      clamp_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      none_r  <= none_nxt;
      zero_r  <= zero_nxt;
      clamp_r <= clamp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    dv_r   <= dv_nxt;
    q_r    <= q_nxt;
    cand_r <= cand_nxt;
    gap_r  <= gap_nxt;
  end

endmodule

// ===== rtl/icsr_back.sv =====
// ----------------------------------------------------------------------------
// icsr_back: run computation and result emission
// Sequences both axis units per pixel, then walks the nx by ny block of
// destination pixels in raster order into a result register.
// ----------------------------------------------------------------------------
module icsr_back #(
  parameter int FB_ROW_LENGTH = icsr_pkg::FB_ROW_LENGTH_DEF,
  parameter int MAX_REPEAT    = icsr_pkg::MAX_REPEAT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  icsr_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_ready,
  input  icsr_pkg::pix_t  q_data,
  icsr_out_if.source      out_ch
);
  import icsr_pkg::*;

  localparam int              CNT_W   = $clog2(MAX_REPEAT + 1);
  localparam logic [FB_W-1:0] ROW_LEN = FB_W'(FB_ROW_LENGTH);

  back_state_t         state_r, state_nxt;
  axis_ctl_t           ctl;

  logic [DIVC_W-1:0]   divc_r, divc_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic [FB_W-1:0]     col_base_r, col_base_nxt;
  logic [FB_W-1:0]     col_r, col_nxt;
  logic [FB_W-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [FB_W-1:0]     out_fb_r, out_fb_nxt;
  logic [COLOR_W-1:0]  out_color_r, out_color_nxt;
  logic                out_last_r, out_last_nxt;

  logic [DEST_W-1:0]   dlo_x, dlo_y;
  logic [CNT_W-1:0]    nx, ny;
  logic                done_x, done_y;
  logic                div_last, row_end, run_last, empty_run, emit;
  logic [FB_W-1:0]     col0;

  icsr_axis #(.MAX_REPEAT(MAX_REPEAT)) u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .pos   (q_data.x),
    .start (cfg.region_left),
    .span  (cfg.region_width),
    .limit (cfg.source_width),
    .dest  (cfg.dest_width),
    .d_lo  (dlo_x),
    .hits  (nx),
    .done  (done_x)
  );

  icsr_axis #(.MAX_REPEAT(MAX_REPEAT)) u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .pos   (q_data.y),
    .start (cfg.region_top),
    .span  (cfg.region_height),
    .limit (cfg.source_height),
    .dest  ({{(DEST_W-DESTH_W){1'b0}}, cfg.dest_height}),
    .d_lo  (dlo_y),
    .hits  (ny),
    .done  (done_y)
  );

  assign div_last  = (divc_r == DIVC_W'(DIV_STEPS - 1));
  assign row_end   = (i_r == CNT_W'(nx - 1'b1));
  assign run_last  = row_end && (j_r == CNT_W'(ny - 1'b1));
  assign empty_run = (nx == '0) || (ny == '0);
  assign emit      = (state_r == B_EMIT) && (!out_valid_r || out_ch.ready);
  assign col0      = FB_W'(dlo_x) * ROW_LEN;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) state_nxt = B_MUL;
      end
      B_MUL:  state_nxt = B_DIV;
      B_DIV: begin
        if (div_last) state_nxt = B_INIT;
      end
      B_INIT: state_nxt = B_CNT;
      B_CNT: begin
        if (done_x && done_y) state_nxt = B_PREP;
      end
      B_PREP: state_nxt = empty_run ? B_IDLE : B_EMIT;
      B_EMIT: begin
        if (emit && run_last) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl     = '0;
    q_ready = 1'b0;
    case (state_r)
      B_IDLE: begin
        q_ready  = 1'b1;
        ctl.load = q_valid;
      end
      B_MUL:  ctl.mul  = 1'b1;
      B_DIV:  ctl.div  = 1'b1;
      B_INIT: ctl.init = 1'b1;
      B_CNT:  ctl.cnt  = 1'b1;
      default: begin
        ctl     = '0;
        q_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    divc_nxt      = divc_r;
    color_nxt     = color_r;
    col_base_nxt  = col_base_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_fb_nxt    = out_fb_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (state_r == B_IDLE && q_valid) begin
      color_nxt = q_data.color;
    end
    if (state_r == B_MUL) begin
      divc_nxt = '0;
    end
    if (state_r == B_DIV) begin
      divc_nxt = divc_r + 1'b1;
    end
    if (state_r == B_PREP) begin
      col_base_nxt = col0;
      col_nxt      = col0;
      row_nxt      = ROW_LEN - 1'b1 - FB_W'(dlo_y);
      i_nxt        = '0;
      j_nxt        = '0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_fb_nxt    = col_r + row_r;
      out_color_nxt = color_r;
      out_last_nxt  = run_last;
      if (row_end) begin
        i_nxt   = '0;
        j_nxt   = j_r + 1'b1;
        col_nxt = col_base_r;
        row_nxt = row_r - 1'b1;
      end else begin
        i_nxt   = i_r + 1'b1;
        col_nxt = col_r + ROW_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      divc_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      divc_r      <= divc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    color_r     <= color_nxt;
    col_base_r  <= col_base_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    out_fb_r    <= out_fb_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fb_index    = out_fb_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// ===== rtl/indexed_color_scaler_rotated_core.sv =====
// ----------------------------------------------------------------------------
// indexed_color_scaler_rotated_core: palette nearest-neighbor scaler, top
// Path: an accepted source pixel passes the front stage register and the
//   queue; the back end registers each result in its output register.
// Per pixel: run search (the 10-step divider sets most of it), then the
//   results, which stall while out_ch is not ready; a palette write
//   finishes in the front. The queue lets intake run ahead of the back end.
// Reset: synchronous, active low; control and config registers take their reset values,
//   queue and result register empty. Palette contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_color_scaler_rotated_core #(
  parameter int FB_ROW_LENGTH   = icsr_pkg::FB_ROW_LENGTH_DEF,
  parameter int PALETTE_ENTRIES = icsr_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_REPEAT      = icsr_pkg::MAX_REPEAT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [icsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icsr_pkg::CFG_DW-1:0]     cfg_wdata,
  icsr_in_if.sink                         in_ch,
  icsr_out_if.source                      out_ch
);
  import icsr_pkg::*;

  // Dataflow:
  //   front : takes requests. Palette writes pack RGB888 -> RGB565 into the
  //           store and finish there. Pixels read their color (registered
  //           read) and sit in a one-entry stage.
  //   queue : short FIFO of classified pixels (position + color). Since the
  //           color is read in order at intake, a later palette write can
  //           not disturb a pixel already queued.
  //   back  : per pixel, each axis finds the lowest destination position d
  //           with clamp(start + floor(d*span/dest)) == pos via a restoring
  //           divider, counts the run (capped at MAX_REPEAT), then emits
  //           the nx x ny block, dy outer, dx inner, through an output
  //           register so the next pixel can start while a result waits.

  cfg_t  cfg_r, cfg_nxt;

  logic  f2q_valid, f2q_ready;
  pix_t  f2q_data;
  logic  q2b_valid, q2b_ready;
  pix_t  q2b_data;

  // configuration registers; the user must write them only while the block is idle (not enforced here)
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  cfg_nxt.source_width  = cfg_wdata[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: cfg_nxt.source_height = cfg_wdata[SIZE_W-1:0];
        REG_REGION_LEFT:   cfg_nxt.region_left   = cfg_wdata[POS_W-1:0];
        REG_REGION_TOP:    cfg_nxt.region_top    = cfg_wdata[POS_W-1:0];
        REG_REGION_WIDTH:  cfg_nxt.region_width  = cfg_wdata[SIZE_W-1:0];
        REG_REGION_HEIGHT: cfg_nxt.region_height = cfg_wdata[SIZE_W-1:0];
        REG_DEST_WIDTH:    cfg_nxt.dest_width    = cfg_wdata[DEST_W-1:0];
        REG_DEST_HEIGHT:   cfg_nxt.dest_height   = cfg_wdata[DESTH_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // intake + palette
  icsr_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .push_data  (f2q_data)
  );

  // decouples intake from run computation
  icsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .push_data  (f2q_data),
    .pop_valid  (q2b_valid),
    .pop_ready  (q2b_ready),
    .pop_data   (q2b_data)
  );

  // run search and result emission
  icsr_back #(
    .FB_ROW_LENGTH (FB_ROW_LENGTH),
    .MAX_REPEAT    (MAX_REPEAT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q2b_valid),
    .q_ready (q2b_ready),
    .q_data  (q2b_data),
    .out_ch  (out_ch)
  );

endmodule
